// ===== rtl/lcw_pkg.sv =====
// Shared types and constants for the LCW (format 80) stream decoder.
// Holds the item and result payloads, decoder phase and run-kind codes.
// No dependencies; compile before every other file of the block.
package lcw_pkg;

    localparam int unsigned LCW_HISTORY_DEPTH = 65536;
    localparam int unsigned POS_W             = 16;

    typedef logic [POS_W-1:0] pos_t;

    // Item kinds
    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Header codes
    localparam logic [7:0] HDR_END   = 8'h80;
    localparam logic [7:0] HDR_FILL  = 8'hFE;
    localparam logic [7:0] HDR_BLOCK = 8'hFF;

    localparam pos_t COPY_BIAS = pos_t'(3);
    localparam pos_t POS_ONE   = pos_t'(1);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_OP0     = 3'd1,
        PH_OP1     = 3'd2,
        PH_OP2     = 3'd3,
        PH_OP3     = 3'd4,
        PH_LITERAL = 3'd5,
        PH_RUN     = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_COPY    = 2'd1,
        KIND_FILL    = 2'd2,
        KIND_LITERAL = 2'd3
    } kind_t;

    typedef struct packed {
        logic       command;
        logic [7:0] in_byte;
    } lcw_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       wants_byte;
        logic       stream_end;
        logic       wrong_kind;
    } lcw_result_t;

    // History write request from the parser to the history store
    typedef struct packed {
        logic       en;
        pos_t       pos;
        logic [7:0] data;
    } hist_wr_t;

endpackage

// ===== rtl/lcw_chan_if.sv =====
// Valid/ready channel carrying one payload per transfer.
// Payload type is a parameter; the decoder uses the types of lcw_pkg.
interface lcw_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lcw_hist.sv =====
// History store of decoded bytes: one write and one registered read per cycle.
// Forwards the write of the same edge so the read data is always current.
// Depends on lcw_pkg.
module lcw_hist #(
    parameter int unsigned DEPTH = lcw_pkg::LCW_HISTORY_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lcw_pkg::hist_wr_t wr,
    input  lcw_pkg::pos_t    rd_pos,
    output logic [7:0]       rd_data
);
    import lcw_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [7:0]    fwd_data_reg;
    logic          fwd_hit_reg;
    logic          fwd_hit_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.pos[AW-1:0]] <= wr.data;
        end
        rd_data_reg  <= mem[rd_pos[AW-1:0]];
        fwd_data_reg <= wr.data;
    end

    // The read above sees the old entry when the same edge writes it
    assign fwd_hit_next = wr.en && (wr.pos[AW-1:0] == rd_pos[AW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

// ===== rtl/lcw_parse.sv =====
// Command parser and run sequencer: holds the decoder state, handles one
// item per cycle while accept is high, drives the history write and the
// next read position. Depends on lcw_pkg.
module lcw_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  lcw_pkg::lcw_item_t    item,
    input  logic [7:0]            rd_data,
    output lcw_pkg::pos_t         rd_pos,
    output lcw_pkg::hist_wr_t     wr,
    output lcw_pkg::lcw_result_t  res
);
    import lcw_pkg::*;

    pos_t       wp_reg, wp_next;
    pos_t       rp_reg, rp_next;
    pos_t       count_reg, count_next;
    logic [7:0] fill_reg, fill_next;
    logic [7:0] hdr_reg, hdr_next;
    phase_t     phase_reg, phase_next;
    kind_t      kind_reg, kind_next;

    logic       start_v;
    kind_t      start_kind_v;
    logic [7:0] byte_v;
    logic       last_v;

    assign last_v = (count_reg == POS_ONE);

    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        count_next   = count_reg;
        fill_next    = fill_reg;
        hdr_next     = hdr_reg;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        start_v      = 1'b0;
        start_kind_v = KIND_NONE;
        byte_v       = item.in_byte;
        wr           = '0;
        res          = '0;

        if (accept)
        begin
            if (item.command == CMD_STEP)
            begin
                if (phase_reg != PH_RUN)
                begin
                    res.wrong_kind = 1'b1;
                end
                else
                begin
                    if (kind_reg == KIND_FILL)
                    begin
                        byte_v = fill_reg;
                    end
                    else
                    begin
                        byte_v  = rd_data;
                        rp_next = rp_reg + POS_ONE;
                    end
                    wr.en         = 1'b1;
                    wr.pos        = wp_reg;
                    wr.data       = byte_v;
                    wp_next       = wp_reg + POS_ONE;
                    res.out_byte  = byte_v;
                    res.out_valid = 1'b1;
                    count_next    = count_reg - POS_ONE;
                    if (last_v)
                    begin
                        phase_next = PH_HEADER;
                        kind_next  = KIND_NONE;
                    end
                end
            end
            else if (phase_reg == PH_RUN)
            begin
                res.wrong_kind = 1'b1;
            end
            else if (phase_reg == PH_LITERAL)
            begin
                wr.en         = 1'b1;
                wr.pos        = wp_reg;
                wr.data       = item.in_byte;
                wp_next       = wp_reg + POS_ONE;
                res.out_byte  = item.in_byte;
                res.out_valid = 1'b1;
                count_next    = count_reg - POS_ONE;
                if (last_v)
                begin
                    phase_next = PH_HEADER;
                    kind_next  = KIND_NONE;
                end
            end
            else if (phase_reg == PH_HEADER)
            begin
                hdr_next = item.in_byte;
                priority if (item.in_byte == HDR_END)
                begin
                    res.stream_end = 1'b1;
                    wp_next        = '0;
                    kind_next      = KIND_NONE;
                end
                else if (!item.in_byte[7])
                begin
                    phase_next = PH_OP0;
                end
                else if (!item.in_byte[6])
                begin
                    count_next = pos_t'(item.in_byte[5:0]);
                    kind_next  = KIND_LITERAL;
                    phase_next = PH_LITERAL;
                end
                else
                begin
                    phase_next = PH_OP0;
                end
            end
            else
            begin
                // Operand bytes of the current header
                priority if (!hdr_reg[7])
                begin
                    rp_next      = wp_reg - pos_t'({hdr_reg[3:0], item.in_byte});
                    count_next   = pos_t'(hdr_reg[6:4]) + COPY_BIAS;
                    start_v      = 1'b1;
                    start_kind_v = KIND_COPY;
                end
                else if (hdr_reg == HDR_FILL)
                begin
                    unique case (phase_reg)
                        PH_OP0:
                        begin
                            count_next = pos_t'(item.in_byte);
                            phase_next = PH_OP1;
                        end
                        PH_OP1:
                        begin
                            count_next = {item.in_byte, count_reg[7:0]};
                            phase_next = PH_OP2;
                        end
                        default:
                        begin
                            fill_next    = item.in_byte;
                            start_v      = 1'b1;
                            start_kind_v = KIND_FILL;
                        end
                    endcase
                end
                else if (hdr_reg == HDR_BLOCK)
                begin
                    unique case (phase_reg)
                        PH_OP0:
                        begin
                            count_next = pos_t'(item.in_byte);
                            phase_next = PH_OP1;
                        end
                        PH_OP1:
                        begin
                            count_next = {item.in_byte, count_reg[7:0]};
                            phase_next = PH_OP2;
                        end
                        PH_OP2:
                        begin
                            rp_next    = pos_t'(item.in_byte);
                            phase_next = PH_OP3;
                        end
                        default:
                        begin
                            rp_next      = {item.in_byte, rp_reg[7:0]};
                            start_v      = 1'b1;
                            start_kind_v = KIND_COPY;
                        end
                    endcase
                end
                else
                begin
                    if (phase_reg == PH_OP0)
                    begin
                        rp_next    = pos_t'(item.in_byte);
                        phase_next = PH_OP1;
                    end
                    else
                    begin
                        rp_next      = {item.in_byte, rp_reg[7:0]};
                        count_next   = pos_t'(hdr_reg[5:0]) + COPY_BIAS;
                        start_v      = 1'b1;
                        start_kind_v = KIND_COPY;
                    end
                end
            end

            // Empty run: drop straight back to the header
            if (start_v)
            begin
                if (count_next == '0)
                begin
                    kind_next  = KIND_NONE;
                    phase_next = PH_HEADER;
                end
                else
                begin
                    kind_next  = start_kind_v;
                    phase_next = PH_RUN;
                end
            end
        end

        res.wants_byte = (phase_next != PH_RUN);
    end

    assign rd_pos = rp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
            fill_reg  <= '0;
            hdr_reg   <= '0;
            phase_reg <= PH_HEADER;
            kind_reg  <= KIND_NONE;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            hdr_reg   <= hdr_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
        end
    end

    a_run_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RUN || phase_reg == PH_LITERAL) |-> (count_reg != '0))
        else $error("run phase with empty count");

    a_run_kind_match: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RUN) |-> (kind_reg == KIND_COPY || kind_reg == KIND_FILL))
        else $error("run phase without copy or fill kind");

    a_wrong_kind_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.wrong_kind) |=> ($stable(wp_reg) && $stable(phase_reg)
            && $stable(count_reg) && $stable(rp_reg)))
        else $error("ignored item changed decoder state");

    a_output_writes_history: assert property (@(posedge clk) disable iff (!rst_n)
        res.out_valid |-> (wr.en && wr.pos == wp_reg && wr.data == res.out_byte))
        else $error("emitted byte not written to history");

endmodule

// ===== rtl/lcw_format80_decompressor.sv =====
// LCW (format 80) decoder top level: parser, history store, result register.
// Each result is registered as its item is taken. Throughput: 1 item per cycle
// unless rsp stalls; each step reads history through a registered read port,
// with same-edge write forwarding for overlapping copies.
// Reset: decoder state cleared at once; history is not cleared and an entry
// reads as undefined until written, so no clearing pass is needed.
module lcw_format80_decompressor #(
    parameter int unsigned HISTORY_DEPTH = lcw_pkg::LCW_HISTORY_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    lcw_chan_if.sink    cmd,
    lcw_chan_if.source  rsp
);
    import lcw_pkg::*;

    logic         accept;
    lcw_item_t    item;
    pos_t         rd_pos;
    logic [7:0]   rd_data;
    hist_wr_t     wr;
    lcw_result_t  res;

    logic         rsp_valid_reg, rsp_valid_next;
    lcw_result_t  rsp_data_reg;

    // Take a new item whenever the result register is empty or drains now
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign item      = cmd.payload;

    lcw_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .rd_data (rd_data),
        .rd_pos  (rd_pos),
        .wr      (wr),
        .res     (res)
    );

    lcw_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_pos  (rd_pos),
        .rd_data (rd_data)
    );

    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

endmodule
